// ===== rtl/mma_pkg.sv =====
// Shared constants, types and the channel remap table for the moving-average bank.
package mma_pkg;

  localparam int WINDOW      = 10;
  localparam int CHANNELS    = 8;
  localparam int MAX_MUX     = 4;
  localparam int SAMPLE_BITS = 10;

  localparam int MUX_W     = 2;
  localparam int CHAN_W    = 3;
  localparam int NUM_MUX_W = 3;
  localparam int AVG_W     = 10;
  localparam int SEL_W     = 3;

  localparam int LANES   = MAX_MUX * CHANNELS;
  localparam int LANE_W  = MUX_W + CHAN_W;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int HIST_AW = LANE_W + SLOT_W;
  localparam int HIST_DEPTH = LANES << SLOT_W;

  localparam int SUM_MAX = WINDOW * ((1 << SAMPLE_BITS) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  // Division by WINDOW as a multiply by a rounded-up reciprocal
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT - $clog2(WINDOW) + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

  typedef struct packed {
    logic               busy;
    logic [HIST_AW-1:0] addr;
  } clr_t;

  function automatic logic [SEL_W-1:0] remap(input logic [CHAN_W-1:0] chan);
    logic [SEL_W-1:0] code;
    case (chan)
      3'd0:    code = 3'd4;
      3'd1:    code = 3'd6;
      3'd2:    code = 3'd7;
      3'd3:    code = 3'd5;
      3'd4:    code = 3'd3;
      3'd5:    code = 3'd0;
      3'd6:    code = 3'd1;
      default: code = 3'd2;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/mma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mma_clear.sv =====
// Clearing sweep over the history and sum memories after reset.
module mma_clear (
  input  logic          clk_i,
  input  logic          rst_ni,
  output mma_pkg::clr_t clr_o
);
  import mma_pkg::*;

  logic               busy_q, busy_d;
  logic [HIST_AW-1:0] addr_q, addr_d;

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      addr_d = addr_q + HIST_AW'(1);
      if (addr_q == HIST_AW'(HIST_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = addr_q;

endmodule

// ===== rtl/multichannel_moving_average.sv =====
// Top level of the multichannel boxcar moving-average filter bank.
// Each transfer on the input carries one sample for one (multiplexer, channel) lane; the
// block returns that lane's running sum divided by the window length, with the physical
// select code of the channel. After reset it sweeps every history entry clear, one per
// cycle, with in_ready_o low; configuration writes are taken throughout. Then it takes one
// sample per cycle unless the output stalls; each result goes through the read stage, the
// divide stage and the output register. The rate is set by the read-modify-write of the
// history and sum memories, one read and one write per memory each cycle, with the
// previous sample's write forwarded when it hits the same entry. Samples for a
// multiplexer at or above num_mux give no result; end_of_sweep still advances the slot.
module multichannel_moving_average (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mma_pkg::NUM_MUX_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mma_pkg::MUX_W-1:0]     mux_index_i,
  input  logic [mma_pkg::CHAN_W-1:0]    channel_index_i,
  input  logic [9:0]                    sample_i,
  input  logic                          end_of_sweep_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mma_pkg::AVG_W-1:0]     average_o,
  output logic [mma_pkg::MUX_W-1:0]     out_mux_o,
  output logic [mma_pkg::CHAN_W-1:0]    out_channel_o,
  output logic [mma_pkg::SEL_W-1:0]     select_code_o
);
  import mma_pkg::*;

  clr_t clr;

  logic [NUM_MUX_W-1:0] num_mux_q;
  logic [SLOT_W-1:0]    slot_q, slot_d;

  // input side
  logic                   accept, in_use, take;
  logic [LANE_W-1:0]      lane;
  logic [HIST_AW-1:0]     hist_raddr;
  logic [SAMPLE_BITS-1:0] smp;

  // read stage
  logic                   s1_v_q, s1_go;
  logic [MUX_W-1:0]       s1_mux_q;
  logic [CHAN_W-1:0]      s1_chan_q;
  logic [SEL_W-1:0]       s1_sel_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;
  logic [HIST_AW-1:0]     s1_haddr_q;
  logic                   s1_fwd_sum_q, s1_fwd_hist_q;
  logic [SUM_W-1:0]       s1_fsum_q;
  logic [SAMPLE_BITS-1:0] s1_fhist_q;
  logic [SUM_W-1:0]       sum_rdata, sum_old, sum_new;
  logic [SAMPLE_BITS-1:0] hist_rdata, hist_old;

  // divide stage
  logic              s2_v_q, s2_go;
  logic [SUM_W-1:0]  s2_sum_q;
  logic [MUX_W-1:0]  s2_mux_q;
  logic [CHAN_W-1:0] s2_chan_q;
  logic [SEL_W-1:0]  s2_sel_q;
  logic [PROD_W-1:0] prod;

  // output register
  logic              out_v_q;
  logic [AVG_W-1:0]  out_avg_q;
  logic [MUX_W-1:0]  out_mux_q;
  logic [CHAN_W-1:0] out_chan_q;
  logic [SEL_W-1:0]  out_sel_q;

  // memory write ports
  logic                   hist_we, sum_we;
  logic [HIST_AW-1:0]     hist_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata;
  logic [LANE_W-1:0]      sum_waddr;
  logic [SUM_W-1:0]       sum_wdata;

  mma_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // Stage handshakes: each stage moves on when the next one is empty or moving
  assign s2_go      = s2_v_q && (!out_v_q || out_ready_i);
  assign s1_go      = s1_v_q && (!s2_v_q || s2_go);
  assign in_ready_o = !clr.busy && (!s1_v_q || s1_go);
  assign accept     = in_valid_i && in_ready_o;

  assign in_use = ({1'b0, mux_index_i} < num_mux_q) &&
                  ({1'b0, mux_index_i} < NUM_MUX_W'(MAX_MUX));
  assign take       = accept && in_use;
  assign lane       = {mux_index_i, channel_index_i};
  assign hist_raddr = {lane, slot_q};
  assign smp        = sample_i[SAMPLE_BITS-1:0];

  always_comb begin
    slot_d = slot_q;
    if (accept && end_of_sweep_i) begin
      slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_mux_q <= NUM_MUX_W'(1);
      slot_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        num_mux_q <= cfg_wdata_i;
      end
      slot_q <= slot_d;
    end
  end

  mma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (take),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  mma_ram #(
    .WIDTH (SUM_W),
    .DEPTH (LANES)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (take),
    .raddr_i (lane),
    .rdata_o (sum_rdata)
  );

  // Read stage: take forwarded values where the previous sample wrote the same entry
  assign sum_old  = s1_fwd_sum_q  ? s1_fsum_q  : sum_rdata;
  assign hist_old = s1_fwd_hist_q ? s1_fhist_q : hist_rdata;
  assign sum_new  = sum_old - SUM_W'(hist_old) + SUM_W'(s1_smp_q);

  always_comb begin
    hist_we    = s1_go;
    hist_waddr = s1_haddr_q;
    hist_wdata = s1_smp_q;
    sum_we     = s1_go;
    sum_waddr  = s1_haddr_q[HIST_AW-1 -: LANE_W];
    sum_wdata  = sum_new;
    if (clr.busy) begin
      hist_we    = 1'b1;
      hist_waddr = clr.addr;
      hist_wdata = '0;
      sum_we     = 1'b1;
      sum_waddr  = clr.addr[LANE_W-1:0];
      sum_wdata  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= take;
      end
      if (!s2_v_q || s2_go) begin
        s2_v_q <= s1_go;
      end
      if (!out_v_q || out_ready_i) begin
        out_v_q <= s2_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_mux_q      <= mux_index_i;
      s1_chan_q     <= channel_index_i;
      s1_sel_q      <= remap(channel_index_i);
      s1_smp_q      <= smp;
      s1_haddr_q    <= hist_raddr;
      s1_fwd_sum_q  <= s1_v_q && (s1_haddr_q[HIST_AW-1 -: LANE_W] == lane);
      s1_fwd_hist_q <= s1_v_q && (s1_haddr_q == hist_raddr);
      s1_fsum_q     <= sum_new;
      s1_fhist_q    <= s1_smp_q;
    end
    if (s1_go) begin
      s2_sum_q  <= sum_new;
      s2_mux_q  <= s1_mux_q;
      s2_chan_q <= s1_chan_q;
      s2_sel_q  <= s1_sel_q;
    end
    if (s2_go) begin
      out_avg_q  <= prod[SHIFT +: AVG_W];
      out_mux_q  <= s2_mux_q;
      out_chan_q <= s2_chan_q;
      out_sel_q  <= s2_sel_q;
    end
  end

  // Divide the sum by the window length
  assign prod = PROD_W'(s2_sum_q) * PROD_W'(RECIP);

  assign out_valid_o   = out_v_q;
  assign average_o     = out_avg_q;
  assign out_mux_o     = out_mux_q;
  assign out_channel_o = out_chan_q;
  assign select_code_o = out_sel_q;

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr.busy |-> (!in_ready_o && !s1_v_q && !s2_v_q))
    else $error("sample in flight during clearing sweep");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(WINDOW - 1))
    else $error("window slot out of range");

  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (SUM_W'(sum_new) <= SUM_W'(SUM_MAX)))
    else $error("channel sum exceeds window bound");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_go) |=> (s1_v_q && $stable(s1_haddr_q) && $stable(sum_rdata)))
    else $error("stalled read stage lost its entry");

  a_fwd_lane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s1_v_q && (s1_haddr_q == hist_raddr)) |=> (s1_fwd_sum_q && s1_fwd_hist_q))
    else $error("missed forwarding on same history entry");

endmodule

// ===== verif/tb_multichannel_moving_average.sv =====
// Self-checking testbench for the multichannel moving-average filter bank.
`timescale 1ns / 1ps

module tb_multichannel_moving_average;
  import mma_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_PHASE   = 6;

  // num_mux per random phase, with the item count of each phase
  localparam int PHASE_MUX [9]   = '{4, 0, 7, 2, 3, 1, 5, 4, 6};
  localparam int PHASE_ITEMS [9] = '{80, 30, 80, 80, 80, 80, 80, 80, 80};

  // logical channel to physical select lines
  localparam logic [SEL_W-1:0] SEL_CODE [CHANNELS] = '{3'd4, 3'd6, 3'd7, 3'd5,
                                                        3'd3, 3'd0, 3'd1, 3'd2};

  typedef struct packed {
    logic [MUX_W-1:0]  mux;
    logic [CHAN_W-1:0] chan;
    logic [9:0]        smp;
    logic              eos;
  } sample_item_t;

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic [MUX_W-1:0]  mux;
    logic [CHAN_W-1:0] chan;
    logic [SEL_W-1:0]  sel;
  } avg_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [NUM_MUX_W-1:0] cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [MUX_W-1:0]     mux_index_i     = '0;
  logic [CHAN_W-1:0]    channel_index_i = '0;
  logic [9:0]           sample_i        = '0;
  logic                 end_of_sweep_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [AVG_W-1:0]     average_o;
  logic [MUX_W-1:0]     out_mux_o;
  logic [CHAN_W-1:0]    out_channel_o;
  logic [SEL_W-1:0]     select_code_o;

  // predictor state
  logic [SAMPLE_BITS-1:0] lane_hist [LANES][WINDOW];
  logic [SUM_W-1:0]       lane_sum [LANES];
  int                     win_slot    = 0;
  int                     mux_in_use  = 1;

  sample_item_t pending_samples [$];
  avg_result_t  avg_expected [$];
  sample_item_t live_item     = '0;
  bit           item_live     = 1'b0;
  int           send_gap      = 0;
  int           recv_gap      = 0;
  int           hold_left     = 0;
  bit           hold_ask      = 1'b0;
  bit           hold_taken    = 1'b0;
  bit           send_quiet    = 1'b0;
  bit           recv_quiet    = 1'b0;
  int           error_count   = 0;
  int           cycle_count   = 0;

  multichannel_moving_average DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mux_index_i     (mux_index_i),
    .channel_index_i (channel_index_i),
    .sample_i        (sample_i),
    .end_of_sweep_i  (end_of_sweep_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .average_o       (average_o),
    .out_mux_o       (out_mux_o),
    .out_channel_o   (out_channel_o),
    .select_code_o   (select_code_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 10'd0;
    if (r < 16) return 10'd1023;
    return 10'($urandom_range(1023));
  endfunction

  function automatic void queue_item(input int mux, input int chan, input logic [9:0] smp,
                                     input bit eos);
    sample_item_t it;
    it.mux  = MUX_W'(mux);
    it.chan = CHAN_W'(chan);
    it.smp  = smp;
    it.eos  = eos;
    pending_samples.push_back(it);
  endfunction

  // Update the running sums for one accepted sample and queue its average if its multiplexer is in use
  function automatic void predict_average(input sample_item_t it);
    int          lane;
    int          acc;
    avg_result_t res;
    if (int'(it.mux) < mux_in_use && int'(it.mux) < MAX_MUX) begin
      lane = int'(it.mux) * CHANNELS + int'(it.chan);
      acc  = int'(lane_sum[lane]) - int'(lane_hist[lane][win_slot]) + int'(it.smp);
      lane_hist[lane][win_slot] = it.smp[SAMPLE_BITS-1:0];
      lane_sum[lane]            = SUM_W'(acc);
      res.average = AVG_W'(acc / WINDOW);
      res.mux     = it.mux;
      res.chan    = it.chan;
      res.sel     = SEL_CODE[it.chan];
      avg_expected.push_back(res);
    end
    if (it.eos) win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
  endfunction

  // Well-formed sweeps with random content, plus cut-short sweeps and loose samples
  task automatic queue_random(input int n_items);
    int left;
    int r;
    int span;
    int len;
    left = n_items;
    while (left > 0) begin
      r    = $urandom_range(99);
      span = (mux_in_use == 0) ? $urandom_range(1, MAX_MUX) :
             ((mux_in_use > MAX_MUX) ? MAX_MUX : mux_in_use);
      if (r < 75) begin
        for (int m = 0; m < span; m++)
          for (int c = 0; c < CHANNELS; c++)
            queue_item(m, c, rand_sample(), (m == span - 1) && (c == CHANNELS - 1));
        left -= span * CHANNELS;
      end else if (r < 88) begin
        len = $urandom_range(1, span * CHANNELS - 1);
        for (int k = 0; k < len; k++)
          queue_item(k / CHANNELS, k % CHANNELS, rand_sample(), 1'b0);
        left -= len;
      end else begin
        queue_item($urandom_range(3), $urandom_range(7), rand_sample(),
                   1'($urandom_range(1)));
        left--;
      end
    end
  endtask

  // Hold until every item is sent and every average has come back, then let the pipe settle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || item_live || avg_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_num_mux(input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= NUM_MUX_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mux_in_use  = value;
  endtask

  // Sender: present one transfer at a time from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_live && in_ready_o === 1'b1) begin
        predict_average(live_item);
        item_live = 1'b0;
      end
      if (!item_live) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() != 0) begin
          live_item = pending_samples.pop_front();
          item_live = 1'b1;
          send_gap  = pick_gap(send_quiet);
        end
      end
      in_valid_i      <= item_live;
      mux_index_i     <= live_item.mux;
      channel_index_i <= live_item.chan;
      sample_i        <= live_item.smp;
      end_of_sweep_i  <= live_item.eos;
    end
  end

  // Receiver back-pressure, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_ask && !hold_taken) begin
      hold_taken  = 1'b1;
      hold_left   = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else begin
      recv_gap    = pick_gap(recv_quiet);
      out_ready_i <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expected average
  always @(posedge clk_i) begin
    avg_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (avg_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result mux %0d chan %0d avg %0d",
                                  out_mux_o, out_channel_o, average_o));
      end else begin
        want = avg_expected.pop_front();
        if (average_o !== want.average)
          report_mismatch($sformatf("average %0d, want %0d", average_o, want.average));
        if (out_mux_o !== want.mux)
          report_mismatch($sformatf("out_mux %0d, want %0d", out_mux_o, want.mux));
        if (out_channel_o !== want.chan)
          report_mismatch($sformatf("out_channel %0d, want %0d", out_channel_o, want.chan));
        if (select_code_o !== want.sel)
          report_mismatch($sformatf("select_code %0d, want %0d", select_code_o, want.sel));
      end
    end
  end

  initial begin
    foreach (lane_sum[l]) begin
      lane_sum[l] = '0;
      foreach (lane_hist[l][s]) lane_hist[l][s] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: one multiplexer; others ignored, end of sweep still advances
    queue_item(0, 0, 10'd0, 1'b0);
    queue_item(0, 7, 10'd1023, 1'b0);
    queue_item(1, 3, 10'd512, 1'b1);
    queue_item(3, 5, 10'd1, 1'b0);
    wait_drained();

    // drive one lane to the full-scale sum across every slot, wrapping the window
    write_num_mux(MAX_MUX);
    for (int k = 0; k < WINDOW; k++) queue_item(3, 7, 10'd1023, 1'b1);
    for (int c = 0; c < CHANNELS - 1; c++)
      queue_item(1 + (c % 2), c, (c % 2) ? 10'h2AA : 10'h155, 1'b0);
    wait_drained();

    foreach (PHASE_MUX[p]) begin
      write_num_mux(PHASE_MUX[p]);
      send_quiet = (p == 3) || (p == HOLD_PHASE);
      recv_quiet = (p == 3) || (p == 5);
      queue_random(PHASE_ITEMS[p]);
      if (p == HOLD_PHASE) hold_ask = 1'b1;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
